### rtl/core/ucem_pkg.sv
// ----------------------------------------------------------------------------
// ucem_pkg: shared types and constants for the UART command echo master
// Item codes, error codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package ucem_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TICK_W     = 24;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = TICK_W;

  localparam logic [TICK_W-1:0] TICK_MAX           = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST  = TICK_W'(1000);
  localparam logic [BYTE_W-1:0] NULL_COMMAND_RST   = '0;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_RX   = 2'd1,
    OP_REQ  = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_TIMEOUT  = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_TICKS = 1'd0,
    CFG_NULL_COMMAND  = 1'd1
  } cfg_idx_t;

endpackage

### rtl/core/ucem_if.sv
// ----------------------------------------------------------------------------
// ucem_if: item channels of the UART command echo master
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface ucem_in_if import ucem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] command;
  logic [BYTE_W-1:0] argument;

  modport source (output valid, op, rx_byte, command, argument, input ready);
  modport sink   (input valid, op, rx_byte, command, argument, output ready);
endinterface

interface ucem_out_if import ucem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              reply_valid;
  logic [BYTE_W-1:0] reply_byte;
  logic [ERR_W-1:0]  error_code;
  logic              busy_res;

  modport source (output valid, tx_valid, tx_byte, reply_valid, reply_byte,
                  error_code, busy_res, input ready);
  modport sink   (input valid, tx_valid, tx_byte, reply_valid, reply_byte,
                  error_code, busy_res, output ready);
endinterface

### rtl/core/uart_command_echo_master.sv
// A result is registered and shown in the cycle after its item is transferred.
// Throughput: one item per cycle while results are taken; the result register
//   frees in the same cycle it is taken, so the state update sets the rate.
// Reset (rst, synchronous): idle, counters and pending bytes cleared,
//   timeout_ticks = 1000, null_command = 0, no result pending.
// ----------------------------------------------------------------------------
// uart_command_echo_master: master side of a two-byte UART command exchange
// Sends command, checks the echo, sends argument, returns the reply byte;
// resends a null packet after a timeout or a mismatch wait.
// ----------------------------------------------------------------------------
module uart_command_echo_master import ucem_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ucem_in_if.sink               in_ch,
  ucem_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ECHO,
    PH_REPLY,
    PH_MISMATCH
  } phase_t;

  // configuration
  logic [TICK_W-1:0] timeout_ticks;
  logic [BYTE_W-1:0] null_command;

  // exchange state
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] pending_command, pending_command_next;
  logic [BYTE_W-1:0] pending_argument, pending_argument_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [BYTE_W-1:0] last_reply, last_reply_next;

  // result fields for the current item
  logic              tx_valid_next;
  logic [BYTE_W-1:0] tx_byte_next;
  logic              reply_valid_next;
  err_t              error_next;

  logic              accept;
  logic [TICK_W-1:0] elapsed_inc;
  logic              timed_out;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // saturating tick count; timeout once it passes the limit
  assign elapsed_inc = (elapsed_ticks != TICK_MAX) ? elapsed_ticks + TICK_W'(1)
                                                   : elapsed_ticks;
  assign timed_out   = elapsed_inc > timeout_ticks;

  always_comb begin
    phase_next            = phase;
    pending_command_next  = pending_command;
    pending_argument_next = pending_argument;
    elapsed_ticks_next    = elapsed_ticks;
    last_reply_next       = last_reply;
    tx_valid_next         = 1'b0;
    tx_byte_next          = '0;
    reply_valid_next      = 1'b0;
    error_next            = ERR_NONE;

    unique case (op_t'(in_ch.op))
      OP_REQ: begin
        if (phase == PH_IDLE) begin
          pending_command_next  = in_ch.command;
          pending_argument_next = in_ch.argument;
          phase_next            = PH_ECHO;
          elapsed_ticks_next    = '0;
          tx_valid_next         = 1'b1;
          tx_byte_next          = in_ch.command;
        end
      end
      OP_RX: begin
        if (phase == PH_ECHO) begin
          elapsed_ticks_next = '0;
          if (in_ch.rx_byte == pending_command) begin
            phase_next    = PH_REPLY;
            tx_valid_next = 1'b1;
            tx_byte_next  = pending_argument;
          end else begin
            phase_next = PH_MISMATCH;
            error_next = ERR_MISMATCH;
          end
        end else if (phase == PH_REPLY) begin
          last_reply_next    = in_ch.rx_byte;
          reply_valid_next   = 1'b1;
          phase_next         = PH_IDLE;
          elapsed_ticks_next = '0;
        end
      end
      OP_TICK: begin
        if (phase != PH_IDLE) begin
          elapsed_ticks_next = elapsed_inc;
          if (timed_out) begin
            // mismatch was already flagged when it was seen
            error_next            = (phase == PH_MISMATCH) ? ERR_NONE : ERR_TIMEOUT;
            pending_command_next  = null_command;
            pending_argument_next = null_command;
            phase_next            = PH_ECHO;
            elapsed_ticks_next    = '0;
            tx_valid_next         = 1'b1;
            tx_byte_next          = null_command;
          end
        end
      end
      OP_RSVD: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks    <= TIMEOUT_TICKS_RST;
      null_command     <= NULL_COMMAND_RST;
      phase            <= PH_IDLE;
      pending_command  <= '0;
      pending_argument <= '0;
      elapsed_ticks    <= '0;
      last_reply       <= '0;
      out_ch.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
          CFG_NULL_COMMAND:  null_command  <= cfg_data[BYTE_W-1:0];
        endcase
      end
      if (accept) begin
        phase            <= phase_next;
        pending_command  <= pending_command_next;
        pending_argument <= pending_argument_next;
        elapsed_ticks    <= elapsed_ticks_next;
        last_reply       <= last_reply_next;
        out_ch.valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.tx_valid    <= tx_valid_next;
      out_ch.tx_byte     <= tx_byte_next;
      out_ch.reply_valid <= reply_valid_next;
      out_ch.reply_byte  <= last_reply_next;
      out_ch.error_code  <= error_next;
      out_ch.busy_res    <= (phase_next != PH_IDLE);
    end
  end

endmodule

### rtl/core/ucem_checker.sv
// ----------------------------------------------------------------------------
// ucem_checker: port-level checks for the UART command echo master
// Watches the result channel and cross-checks result fields over time.
// ----------------------------------------------------------------------------
module ucem_checker import ucem_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              tx_valid,
  input logic [BYTE_W-1:0] tx_byte,
  input logic              reply_valid,
  input logic [BYTE_W-1:0] reply_byte,
  input logic [ERR_W-1:0]  error_code,
  input logic              busy_res
);

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({tx_valid, tx_byte, reply_valid, reply_byte, error_code, busy_res}))
    else $error("result changed while stalled");

  // a completed exchange leaves the block idle and sends nothing
  a_reply_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_valid |-> !busy_res && !tx_valid && error_code == ERR_NONE)
    else $error("reply result inconsistent");

  // mismatch: no transmit, wait continues
  a_mismatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_MISMATCH |-> !tx_valid && busy_res)
    else $error("mismatch result inconsistent");

  // timeout: resend starts, exchange stays open
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_TIMEOUT |-> tx_valid && busy_res && !reply_valid)
    else $error("timeout result inconsistent");

  // idle transmit lines carry zero
  a_tx_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_valid |-> tx_byte == '0)
    else $error("tx_byte nonzero without tx_valid");

endmodule

bind uart_command_echo_master ucem_checker u_ucem_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .tx_valid    (out_ch.tx_valid),
  .tx_byte     (out_ch.tx_byte),
  .reply_valid (out_ch.reply_valid),
  .reply_byte  (out_ch.reply_byte),
  .error_code  (out_ch.error_code),
  .busy_res    (out_ch.busy_res)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the UART command echo master
// Drives ticks, received bytes and send requests through the input channel,
// predicts every result with a local copy of the exchange state machine and
// compares each result transfer field by field, under random channel stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ucem_pkg::*;

  typedef enum logic [1:0] {
    LINK_IDLE,
    LINK_ECHO,
    LINK_REPLY,
    LINK_MISMATCH_WAIT
  } link_phase_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] argument;
  } link_item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              reply_valid;
    logic [BYTE_W-1:0] reply_byte;
    err_t              error_code;
    logic              busy;
  } link_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ucem_in_if  in_ch ();
  ucem_out_if out_ch ();

  uart_command_echo_master dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // local copy of the master state and its registers
  link_phase_t       link_phase;
  logic [BYTE_W-1:0] pend_cmd;
  logic [BYTE_W-1:0] pend_arg;
  logic [TICK_W-1:0] wait_ticks;
  logic [BYTE_W-1:0] last_reply;
  logic [TICK_W-1:0] timeout_cfg;
  logic [BYTE_W-1:0] null_cfg;

  link_result_t expected_link_results[$];
  int unsigned  error_count;
  int unsigned  sent_items;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;

  function automatic link_result_t predict_link_step(link_item_t it);
    link_result_t r;
    r = '0;
    case (it.op)
      OP_REQ: begin
        if (link_phase == LINK_IDLE) begin
          pend_cmd   = it.command;
          pend_arg   = it.argument;
          link_phase = LINK_ECHO;
          wait_ticks = '0;
          r.tx_valid = 1'b1;
          r.tx_byte  = it.command;
        end
      end
      OP_RX: begin
        if (link_phase == LINK_ECHO) begin
          wait_ticks = '0;
          if (it.rx_byte == pend_cmd) begin
            link_phase = LINK_REPLY;
            r.tx_valid = 1'b1;
            r.tx_byte  = pend_arg;
          end else begin
            link_phase   = LINK_MISMATCH_WAIT;
            r.error_code = ERR_MISMATCH;
          end
        end else if (link_phase == LINK_REPLY) begin
          last_reply    = it.rx_byte;
          r.reply_valid = 1'b1;
          link_phase    = LINK_IDLE;
          wait_ticks    = '0;
        end
      end
      OP_TICK: begin
        if (link_phase != LINK_IDLE) begin
          if (wait_ticks != TICK_MAX) wait_ticks = wait_ticks + 1'b1;
          if (wait_ticks > timeout_cfg) begin
            // mismatch was already flagged when seen, so the resend is silent
            r.error_code = (link_phase == LINK_MISMATCH_WAIT) ? ERR_NONE : ERR_TIMEOUT;
            pend_cmd     = null_cfg;
            pend_arg     = null_cfg;
            link_phase   = LINK_ECHO;
            wait_ticks   = '0;
            r.tx_valid   = 1'b1;
            r.tx_byte    = null_cfg;
          end
        end
      end
      default: begin
      end
    endcase
    r.reply_byte = last_reply;
    r.busy       = (link_phase != LINK_IDLE);
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic link_item_t make_item(op_t op, logic [BYTE_W-1:0] rx,
                                           logic [BYTE_W-1:0] cmd,
                                           logic [BYTE_W-1:0] arg);
    link_item_t it;
    it.op       = op;
    it.rx_byte  = rx;
    it.command  = cmd;
    it.argument = arg;
    return it;
  endfunction

  function automatic link_item_t rand_item(op_t op);
    return make_item(op, rand_byte(), rand_byte(), rand_byte());
  endfunction

  task automatic report_mismatch(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] got,
                             logic [BYTE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // one transfer on the input channel; valid stays high into the next item
  task automatic send_item(link_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= it.op;
    in_ch.rx_byte  <= it.rx_byte;
    in_ch.command  <= it.command;
    in_ch.argument <= it.argument;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_link_results.push_back(predict_link_step(it));
    sent_items++;
  endtask

  // hold off the sender until every result has been taken
  task automatic settle_link();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_link_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_link_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived",
                                expected_link_results.size()));
      expected_link_results.delete();
    end
  endtask

  task automatic write_cfg(logic [TICK_W-1:0] timeout_val, logic [BYTE_W-1:0] null_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= timeout_val;
    @(posedge clk);
    cfg_index <= CFG_NULL_COMMAND;
    cfg_data  <= CFG_DATA_W'(null_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    timeout_cfg = timeout_val;
    null_cfg    = null_val;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    link_result_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_link_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_link_results.pop_front();
        check_field("tx_valid", BYTE_W'(out_ch.tx_valid), BYTE_W'(want.tx_valid));
        check_field("tx_byte", out_ch.tx_byte, want.tx_byte);
        check_field("reply_valid", BYTE_W'(out_ch.reply_valid), BYTE_W'(want.reply_valid));
        check_field("reply_byte", out_ch.reply_byte, want.reply_byte);
        check_field("error_code", BYTE_W'(out_ch.error_code), BYTE_W'(want.error_code));
        check_field("busy_res", BYTE_W'(out_ch.busy_res), BYTE_W'(want.busy));
      end
    end
  end

  // ticks, bytes and op 3 while idle do nothing; a full exchange at reset config
  task automatic test_idle_and_exchange();
    send_item(rand_item(OP_TICK));
    send_item(make_item(OP_RX, 8'hFF, rand_byte(), rand_byte()));
    send_item(rand_item(OP_RSVD));
    send_item(make_item(OP_REQ, rand_byte(), 8'hFF, 8'h00));
    send_item(make_item(OP_REQ, rand_byte(), 8'h12, 8'h34));
    send_item(make_item(OP_RX, 8'hFF, rand_byte(), rand_byte()));
    send_item(make_item(OP_RX, 8'hA5, rand_byte(), rand_byte()));
    settle_link();
  endtask

  // zero timeout: first tick of any wait resends; mismatch wait and discards
  task automatic test_timeout_and_mismatch();
    write_cfg('0, 8'hFF);
    send_item(make_item(OP_REQ, rand_byte(), 8'h00, 8'hFF));
    send_item(rand_item(OP_TICK));
    send_item(make_item(OP_RX, 8'h00, rand_byte(), rand_byte()));
    send_item(make_item(OP_RX, 8'h55, rand_byte(), rand_byte()));
    send_item(rand_item(OP_TICK));
    send_item(make_item(OP_RX, 8'hFF, rand_byte(), rand_byte()));
    send_item(rand_item(OP_TICK));
    send_item(make_item(OP_RX, 8'hFF, rand_byte(), rand_byte()));
    send_item(make_item(OP_RX, 8'h00, rand_byte(), rand_byte()));
    settle_link();
  endtask

  // largest timeout: waits never expire
  task automatic test_longest_timeout();
    write_cfg(TICK_MAX, 8'h00);
    send_item(make_item(OP_REQ, rand_byte(), 8'h5A, 8'hA5));
    repeat (3) send_item(rand_item(OP_TICK));
    send_item(rand_item(OP_RSVD));
    send_item(make_item(OP_RX, 8'h5A, rand_byte(), rand_byte()));
    send_item(rand_item(OP_TICK));
    send_item(make_item(OP_RX, 8'h3C, rand_byte(), rand_byte()));
    settle_link();
  endtask

  // mostly well-formed exchanges with random bytes, plus stray and broken items
  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct,
                                     int unsigned n_items);
    int unsigned start;
    int unsigned roll;
    int unsigned seg;
    src_idle_pct  = s_pct;
    sink_idle_pct = r_pct;
    for (seg = 0; seg < 3; seg++) begin
      settle_link();
      write_cfg(TICK_W'($urandom_range(12)), rand_byte());
      start = sent_items;
      while (sent_items - start < n_items / 3) begin
        roll = $urandom_range(99);
        case (link_phase)
          LINK_IDLE: begin
            if (roll < 75) send_item(rand_item(OP_REQ));
            else if (roll < 85) send_item(rand_item(OP_RX));
            else if (roll < 93) send_item(rand_item(OP_TICK));
            else send_item(rand_item(OP_RSVD));
          end
          LINK_ECHO: begin
            if (roll < 60) send_item(make_item(OP_RX, pend_cmd, rand_byte(), rand_byte()));
            else if (roll < 72) send_item(rand_item(OP_RX));
            else if (roll < 90) send_item(rand_item(OP_TICK));
            else if (roll < 95) send_item(rand_item(OP_REQ));
            else send_item(rand_item(OP_RSVD));
          end
          LINK_REPLY: begin
            if (roll < 65) send_item(rand_item(OP_RX));
            else if (roll < 88) send_item(rand_item(OP_TICK));
            else if (roll < 94) send_item(rand_item(OP_REQ));
            else send_item(rand_item(OP_RSVD));
          end
          default: begin
            if (roll < 80) send_item(rand_item(OP_TICK));
            else if (roll < 92) send_item(rand_item(OP_RX));
            else send_item(rand_item(OP_REQ));
          end
        endcase
      end
    end
    settle_link();
  endtask

  initial begin
    error_count   = 0;
    sent_items    = 0;
    link_phase    = LINK_IDLE;
    pend_cmd      = '0;
    pend_arg      = '0;
    wait_ticks    = '0;
    last_reply    = '0;
    timeout_cfg   = TIMEOUT_TICKS_RST;
    null_cfg      = NULL_COMMAND_RST;
    src_idle_pct  = 13;
    sink_idle_pct = 49;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_TIMEOUT_TICKS;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_TICK;
    in_ch.rx_byte  <= '0;
    in_ch.command  <= '0;
    in_ch.argument <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_exchange();
    test_timeout_and_mismatch();
    test_longest_timeout();
    test_random_traffic(13, 49, 450);
    test_random_traffic(49, 13, 450);
    test_random_traffic(0, 0, 450);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
